FILE: rtl/core/srdz_pkg.sv
// shared types, constants and arithmetic steps for the radial deadzone scaler
package srdz_pkg;

	localparam int RAD_W    = 34;  // sum of two squared q1.16 components
	localparam int ROOT_W   = 17;  // radial magnitude, q.16
	localparam int SQREM_W  = 19;  // square root partial remainder
	localparam int DREM_W   = 17;  // long division partial remainder and divisor
	localparam int COMP_W   = 17;  // one normalised component, q1.16
	localparam int S_QBITS  = 31;  // rescaled magnitude quotient bits below the cap
	localparam int AX_QBITS = 7;   // axis quotient bits below the clamp

	localparam logic [7:0]  CENTRE     = 8'h80;
	localparam logic [6:0]  AXIS_CLAMP = 7'd127;
	localparam logic [15:0] DZ_RESET   = 16'd6554;
	localparam logic [6:0]  SPAN_RESET = 7'd100;

	typedef enum logic {
		REG_DEADZONE = 1'b0,
		REG_SPAN     = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [SQREM_W-1:0] rem;
		logic [ROOT_W-1:0]  root;
	} sq_t;

	typedef struct packed {
		logic [DREM_W-1:0] rem;
		logic              q;
	} dv_t;

	// one digit of the bitwise integer square root
	function automatic sq_t sqrt_step(sq_t cur, logic [1:0] pair);
		logic [SQREM_W+1:0] acc;
		logic [SQREM_W+1:0] trial;
		sq_t nxt;
		acc   = {cur.rem, pair};
		trial = {2'b00, cur.root, 2'b01};
		if (acc >= trial) begin
			nxt.rem  = SQREM_W'(acc - trial);
			nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = acc[SQREM_W-1:0];
			nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

	// one quotient bit of restoring long division
	function automatic dv_t div_step(logic [DREM_W-1:0] rem, logic nbit, logic [DREM_W-1:0] den);
		logic [DREM_W:0] acc;
		dv_t nxt;
		acc = {rem, nbit};
		if (acc >= {1'b0, den}) begin
			nxt.rem = DREM_W'(acc - {1'b0, den});
			nxt.q   = 1'b1;
		end else begin
			nxt.rem = acc[DREM_W-1:0];
			nxt.q   = 1'b0;
		end
		return nxt;
	endfunction

endpackage

FILE: rtl/core/stick_radial_deadzone_scaler_core.sv
// top level of the analog stick radial deadzone scaler
//
// maps one signed 16-bit stick pair (raw_x, raw_y) to two centred position
// bytes. one transfer is taken every clock while the output side keeps up;
// each pair comes out in order. the pipe is made of the bitwise square root
// (17 digits, two per stage, 9 stages), the rescale divider (31 quotient
// bits, four per stage, 8 stages) and the final axis divider (7 bits, two
// stages), plus normalise, squaring, multiplier and output stages. the
// whole pipe advances together: when the output register holds a result
// that is not taken, every stage holds and in_ready drops.
// deadzone_fraction (q0.16, addr 0) and output_span (addr 4) are written over
// the apb port; write them only while the pipe is empty. a full deadzone
// still gives a defined result, and a zero span gives 128 on both axes.
module stick_radial_deadzone_scaler_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// sample input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [15:0] raw_x,
	input  logic signed [15:0] raw_y,
	// position output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  axis_x,
	output logic [7:0]  axis_y
);

	localparam int CW = srdz_pkg::COMP_W;
	localparam int RW = srdz_pkg::ROOT_W;
	localparam int DW = srdz_pkg::DREM_W;
	localparam int SQ = srdz_pkg::S_QBITS;
	localparam int AQ = srdz_pkg::AX_QBITS;

	// configuration registers
	logic [15:0] deadzone_q;
	logic [6:0]  span_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q <= srdz_pkg::DZ_RESET;
			span_q     <= srdz_pkg::SPAN_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (srdz_pkg::reg_idx_t'(paddr[2]))
				srdz_pkg::REG_DEADZONE: deadzone_q <= pwdata[15:0];
				srdz_pkg::REG_SPAN:     span_q     <= pwdata[6:0];
				default:                deadzone_q <= deadzone_q;
			endcase
		end
	end

	always_comb begin
		case (srdz_pkg::reg_idx_t'(paddr[2]))
			srdz_pkg::REG_DEADZONE: prdata = {16'b0, deadzone_q};
			srdz_pkg::REG_SPAN:     prdata = {25'b0, span_q};
			default:                prdata = '0;
		endcase
	end

	// global pipe advance: the output register is empty or being taken
	logic adv;
	logic v_s9;
	assign adv      = !v_s9 || out_ready;
	assign in_ready = adv;

	// ---- stage 1: normalise, |2v+1| scaled by 65536/65535 ----
	// |2v+1| is 2v+1 or 2*~v+1, and the scale only changes the full-scale value
	logic [15:0]   tx, ty;
	logic [CW-1:0] cx_s1, cy_s1;
	logic          nx_s1, ny_s1, v_s1;

	assign tx = {raw_x[14:0] ^ {15{raw_x[15]}}, 1'b1};
	assign ty = {raw_y[14:0] ^ {15{raw_y[15]}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s1 <= (tx == 16'hFFFF) ? 17'h10000 : {1'b0, tx};
			cy_s1 <= (ty == 16'hFFFF) ? 17'h10000 : {1'b0, ty};
			nx_s1 <= raw_x[15];
			ny_s1 <= raw_y[15];
		end
	end

	// ---- stage 2: squared radius ----
	logic [33:0]   sum_s2;
	logic [CW-1:0] cx_s2, cy_s2;
	logic          nx_s2, ny_s2, v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2 <= 34'(cx_s1) * 34'(cx_s1) + 34'(cy_s1) * 34'(cy_s1);
			cx_s2  <= cx_s1;
			cy_s2  <= cy_s1;
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;
		end
	end

	// ---- square root pipe ----
	logic          sq_valid;
	logic [RW-1:0] m_sq;
	logic [2*CW+1:0] sq_side;

	srdz_sqrt #(
		.STEPS  (2),
		.SIDE_W (2*CW+2)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s2),
		.rad       (sum_s2),
		.side_in   ({cx_s2, cy_s2, nx_s2, ny_s2}),
		.out_valid (sq_valid),
		.root      (m_sq),
		.side_out  (sq_side)
	);

	// ---- stage 3: deadzone raise and divider setup ----
	// quotient is capped at 2^31, so the top two numerator bits are tested
	// against the divisor and the remaining 31 bits go through the divider
	logic [RW-1:0] mc, diff;
	logic [DW-1:0] den_c;
	logic          ovf_c;

	assign mc    = (m_sq < {1'b0, deadzone_q}) ? {1'b0, deadzone_q} : m_sq;
	assign diff  = mc - {1'b0, deadzone_q};
	assign den_c = 17'h10000 - {1'b0, deadzone_q};
	assign ovf_c = ({15'b0, diff[16:15]} >= den_c);

	logic [RW-1:0] m_s3;
	logic [CW-1:0] cx_s3, cy_s3;
	logic          nx_s3, ny_s3, ovf_s3, v_s3;
	logic [DW-1:0] den_s3, rem0_s3;
	logic [SQ-1:0] bits_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s3    <= m_sq;
			{cx_s3, cy_s3, nx_s3, ny_s3} <= sq_side;
			ovf_s3  <= ovf_c;
			den_s3  <= den_c;
			rem0_s3 <= ovf_c ? '0 : {15'b0, diff[16:15]};
			bits_s3 <= {diff[14:0], 16'b0};
		end
	end

	// ---- rescale divider ----
	logic          dv_valid;
	logic [SQ-1:0] s_quo;
	logic [RW+2*CW+2:0] dv_side;

	srdz_div #(
		.LANES  (1),
		.QBITS  (SQ),
		.STEPS  (4),
		.SIDE_W (RW+2*CW+3)
	) u_sdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s3),
		.den       (den_s3),
		.rem0      (rem0_s3),
		.num       (bits_s3),
		.side_in   ({m_s3, cx_s3, cy_s3, nx_s3, ny_s3, ovf_s3}),
		.out_valid (dv_valid),
		.quo       (s_quo),
		.side_out  (dv_side)
	);

	// ---- stage 4: square of the rescaled magnitude ----
	logic [RW-1:0] m_dv;
	logic [CW-1:0] cx_dv, cy_dv;
	logic          nx_dv, ny_dv, ovf_dv;
	logic [31:0]   s_val;
	logic [63:0]   s_sq;

	assign {m_dv, cx_dv, cy_dv, nx_dv, ny_dv, ovf_dv} = dv_side;
	assign s_val = ovf_dv ? 32'h8000_0000 : {1'b0, s_quo};
	assign s_sq  = 64'(s_val) * 64'(s_val);

	logic [46:0]   q_s4;
	logic [RW-1:0] m_s4;
	logic [CW-1:0] cx_s4, cy_s4;
	logic          nx_s4, ny_s4, v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s4  <= s_sq[62:16];
			m_s4  <= m_dv;
			cx_s4 <= cx_dv;
			cy_s4 <= cy_dv;
			nx_s4 <= nx_dv;
			ny_s4 <= ny_dv;
		end
	end

	// ---- stage 5: span scale, capped at 2^47 ----
	logic [53:0]   tp;
	logic [47:0]   t_s5;
	logic [RW-1:0] m_s5;
	logic [CW-1:0] cx_s5, cy_s5;
	logic          nx_s5, ny_s5, v_s5;

	assign tp = 54'(q_s4) * 54'(span_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s5  <= (tp > (54'd1 << 47)) ? (48'd1 << 47) : tp[47:0];
			m_s5  <= m_s4;
			cx_s5 <= cx_s4;
			cy_s5 <= cy_s4;
			nx_s5 <= nx_s4;
			ny_s5 <= ny_s4;
		end
	end

	// ---- stage 6: component times scale, split in two halves ----
	logic [40:0]   pxl_s6, pxh_s6, pyl_s6, pyh_s6;
	logic [RW-1:0] m_s6;
	logic          nx_s6, ny_s6, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pxl_s6 <= 41'(cx_s5) * 41'(t_s5[23:0]);
			pxh_s6 <= 41'(cx_s5) * 41'(t_s5[47:24]);
			pyl_s6 <= 41'(cy_s5) * 41'(t_s5[23:0]);
			pyh_s6 <= 41'(cy_s5) * 41'(t_s5[47:24]);
			m_s6   <= m_s5;
			nx_s6  <= nx_s5;
			ny_s6  <= ny_s5;
		end
	end

	// ---- stage 7: join halves, drop the q.16 fraction of the divisor ----
	logic [64:0]   fx, fy;
	logic [48:0]   nxv_s7, nyv_s7;
	logic [RW-1:0] m_s7;
	logic          nx_s7, ny_s7, v_s7;

	assign fx = 65'(pxl_s6) + {pxh_s6, 24'b0};
	assign fy = 65'(pyl_s6) + {pyh_s6, 24'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nxv_s7 <= fx[64:16];
			nyv_s7 <= fy[64:16];
			m_s7   <= m_s6;
			nx_s7  <= nx_s6;
			ny_s7  <= ny_s6;
		end
	end

	// ---- stage 8: clamp test, quotient of 128 or more saturates ----
	logic          clx_s8, cly_s8, nx_s8, ny_s8, v_s8;
	logic [DW-1:0] m_s8;
	logic [1:0][DW-1:0] rem0_s8;
	logic [1:0][AQ-1:0] bits_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			clx_s8     <= (nxv_s7[48:7] >= 42'(m_s7));
			cly_s8     <= (nyv_s7[48:7] >= 42'(m_s7));
			rem0_s8[0] <= nxv_s7[23:7];
			rem0_s8[1] <= nyv_s7[23:7];
			bits_s8[0] <= nxv_s7[6:0];
			bits_s8[1] <= nyv_s7[6:0];
			m_s8       <= m_s7;
			nx_s8      <= nx_s7;
			ny_s8      <= ny_s7;
		end
	end

	// ---- axis divider, both lanes share the magnitude ----
	logic               av_valid;
	logic [1:0][AQ-1:0] ax_quo;
	logic [3:0]         av_side;

	srdz_div #(
		.LANES  (2),
		.QBITS  (AQ),
		.STEPS  (4),
		.SIDE_W (4)
	) u_adiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s8),
		.den       (m_s8),
		.rem0      (rem0_s8),
		.num       (bits_s8),
		.side_in   ({nx_s8, ny_s8, clx_s8, cly_s8}),
		.out_valid (av_valid),
		.quo       (ax_quo),
		.side_out  (av_side)
	);

	// ---- stage 9: centring and output register ----
	logic [AQ-1:0] ix, iy;
	logic [7:0]    axis_x_s9, axis_y_s9;

	assign ix = av_side[1] ? srdz_pkg::AXIS_CLAMP : ax_quo[0];
	assign iy = av_side[0] ? srdz_pkg::AXIS_CLAMP : ax_quo[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= av_valid;
		end
	end

	// x grows to the right, y is flipped so that down is larger
	always_ff @(posedge clk) begin
		if (adv) begin
			axis_x_s9 <= av_side[3] ? (srdz_pkg::CENTRE - {1'b0, ix})
			                        : (srdz_pkg::CENTRE + {1'b0, ix});
			axis_y_s9 <= av_side[2] ? (srdz_pkg::CENTRE + {1'b0, iy})
			                        : (srdz_pkg::CENTRE - {1'b0, iy});
		end
	end

	assign out_valid = v_s9;
	assign axis_x    = axis_x_s9;
	assign axis_y    = axis_y_s9;

`ifndef NO_ASSERTIONS
	// radius of any sample is at least one lsb, the axis divider relies on it
	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		sq_valid |-> m_sq != '0)
		else $error("square root gave zero radius");

	// rescale divider starts with a remainder below its divisor
	a_div_setup: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> rem0_s3 < den_s3)
		else $error("rescale divider start remainder out of range");

	// clamp keeps both bytes inside 1..255
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (axis_x != 8'd0) && (axis_y != 8'd0))
		else $error("axis byte wrapped");
`endif

endmodule

FILE: rtl/core/srdz_sqrt.sv
// pipelined integer square root, a few digits per stage
module srdz_sqrt #(
	parameter int STEPS  = 2,
	parameter int SIDE_W = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [srdz_pkg::RAD_W-1:0]        rad,
	input  logic [SIDE_W-1:0]                 side_in,
	output logic                              out_valid,
	output logic [srdz_pkg::ROOT_W-1:0]       root,
	output logic [SIDE_W-1:0]                 side_out
);

	localparam int RW  = srdz_pkg::ROOT_W;
	localparam int AW  = srdz_pkg::RAD_W;
	localparam int NST = (RW + STEPS - 1) / STEPS;

	logic [NST:1]       v_s;
	srdz_pkg::sq_t      sq_s   [1:NST];
	logic [SIDE_W-1:0]  side_s [1:NST];
	logic [AW-1:0]      rad_s  [1:NST-1];

	for (genvar gi = 0; gi < NST; gi++) begin : g_st
		logic [AW-1:0]     rad_c;
		srdz_pkg::sq_t     sq_c;
		logic              v_c;
		logic [SIDE_W-1:0] side_c;
		logic [AW-1:0]     rad_n;
		srdz_pkg::sq_t     sq_n;

		if (gi == 0) begin : g_in
			assign rad_c  = rad;
			assign sq_c   = '0;
			assign v_c    = in_valid;
			assign side_c = side_in;
		end else begin : g_mid
			assign rad_c  = rad_s[gi];
			assign sq_c   = sq_s[gi];
			assign v_c    = v_s[gi];
			assign side_c = side_s[gi];
		end

		always_comb begin
			rad_n = rad_c;
			sq_n  = sq_c;
			for (int j = 0; j < STEPS; j++) begin
				if (gi * STEPS + j < RW) begin
					sq_n  = srdz_pkg::sqrt_step(sq_n, rad_n[AW-1:AW-2]);
					rad_n = {rad_n[AW-3:0], 2'b00};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[gi+1] <= 1'b0;
			end else if (en) begin
				v_s[gi+1] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[gi+1]   <= sq_n;
				side_s[gi+1] <= side_c;
			end
		end

		if (gi < NST - 1) begin : g_rad
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[gi+1] <= rad_n;
				end
			end
		end
	end

	assign out_valid = v_s[NST];
	assign root      = sq_s[NST].root;
	assign side_out  = side_s[NST];

endmodule

FILE: rtl/core/srdz_div.sv
// pipelined restoring long division, lanes share one divisor
module srdz_div #(
	parameter int LANES  = 1,
	parameter int QBITS  = 8,
	parameter int STEPS  = 4,
	parameter int SIDE_W = 1
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         en,
	input  logic                                         in_valid,
	input  logic [srdz_pkg::DREM_W-1:0]                  den,
	input  logic [LANES-1:0][srdz_pkg::DREM_W-1:0]       rem0,
	input  logic [LANES-1:0][QBITS-1:0]                  num,
	input  logic [SIDE_W-1:0]                            side_in,
	output logic                                         out_valid,
	output logic [LANES-1:0][QBITS-1:0]                  quo,
	output logic [SIDE_W-1:0]                            side_out
);

	localparam int DW  = srdz_pkg::DREM_W;
	localparam int NST = (QBITS + STEPS - 1) / STEPS;

	logic [NST:1]                   v_s;
	logic [LANES-1:0][QBITS-1:0]    quo_s  [1:NST];
	logic [SIDE_W-1:0]              side_s [1:NST];
	logic [LANES-1:0][DW-1:0]       rem_s  [1:NST-1];
	logic [LANES-1:0][QBITS-1:0]    num_s  [1:NST-1];
	logic [DW-1:0]                  den_s  [1:NST-1];

	for (genvar gi = 0; gi < NST; gi++) begin : g_st
		logic [LANES-1:0][DW-1:0]    rem_c;
		logic [LANES-1:0][QBITS-1:0] num_c;
		logic [LANES-1:0][QBITS-1:0] quo_c;
		logic [DW-1:0]               den_c;
		logic                        v_c;
		logic [SIDE_W-1:0]           side_c;
		logic [LANES-1:0][DW-1:0]    rem_n;
		logic [LANES-1:0][QBITS-1:0] num_n;
		logic [LANES-1:0][QBITS-1:0] quo_n;

		if (gi == 0) begin : g_in
			assign rem_c  = rem0;
			assign num_c  = num;
			assign quo_c  = '0;
			assign den_c  = den;
			assign v_c    = in_valid;
			assign side_c = side_in;
		end else begin : g_mid
			assign rem_c  = rem_s[gi];
			assign num_c  = num_s[gi];
			assign quo_c  = quo_s[gi];
			assign den_c  = den_s[gi];
			assign v_c    = v_s[gi];
			assign side_c = side_s[gi];
		end

		always_comb begin
			srdz_pkg::dv_t d;
			rem_n = rem_c;
			num_n = num_c;
			quo_n = quo_c;
			for (int j = 0; j < STEPS; j++) begin
				if (gi * STEPS + j < QBITS) begin
					for (int l = 0; l < LANES; l++) begin
						d        = srdz_pkg::div_step(rem_n[l], num_n[l][QBITS-1], den_c);
						rem_n[l] = d.rem;
						num_n[l] = {num_n[l][QBITS-2:0], 1'b0};
						quo_n[l] = {quo_n[l][QBITS-2:0], d.q};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[gi+1] <= 1'b0;
			end else if (en) begin
				v_s[gi+1] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[gi+1]  <= quo_n;
				side_s[gi+1] <= side_c;
			end
		end

		if (gi < NST - 1) begin : g_work
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[gi+1] <= rem_n;
					num_s[gi+1] <= num_n;
					den_s[gi+1] <= den_c;
				end
			end
		end
	end

	assign out_valid = v_s[NST];
	assign quo       = quo_s[NST];
	assign side_out  = side_s[NST];

endmodule

FILE: test/stick_radial_deadzone_scaler_core_tb.sv
// self-checking testbench for the radial deadzone scaler core
module stick_radial_deadzone_scaler_core_tb;

	typedef struct {
		logic [7:0] ax;
		logic [7:0] ay;
	} stick_pos_t;

	// keeps the positions still owed by the core and checks each output transfer
	class position_board;
		stick_pos_t owed[$];
		int errors;
		bit [15:0] dz_q16;
		bit [6:0]  span;

		function new();
			errors = 0;
			dz_q16 = srdz_pkg::DZ_RESET;
			span = srdz_pkg::SPAN_RESET;
		endfunction

		// q1.16 magnitude of 2v+1 and its sign
		function automatic longint unsigned norm_axis(logic signed [15:0] v, output bit neg);
			longint signed t;
			t = 2 * longint'(v) + 1;
			neg = t < 0;
			return ((t < 0 ? -t : t) * 65536) / 65535;
		endfunction

		function automatic longint unsigned isqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function automatic logic [7:0] place(longint unsigned c, bit neg,
			longint unsigned t, longint unsigned m, bit flip);
			longint unsigned i;
			i = (c * t) / (m << 16);
			if (i > 127) i = 127;
			return (neg != flip) ? 8'(128 - i) : 8'(128 + i);
		endfunction

		// works out the position for one accepted sample pair
		function void note_sample(logic signed [15:0] rx, logic signed [15:0] ry);
			bit nx, ny;
			longint unsigned cx, cy, m, mc, s, t;
			stick_pos_t p;
			cx = norm_axis(rx, nx);
			cy = norm_axis(ry, ny);
			m = isqrt(cx * cx + cy * cy);
			mc = (m < dz_q16) ? dz_q16 : m;
			s = ((mc - dz_q16) << 16) / (65536 - dz_q16);
			if (s > (64'd1 << 31)) s = 64'd1 << 31;
			t = ((s * s) >> 16) * span;
			if (t > (64'd1 << 47)) t = 64'd1 << 47;
			p.ax = place(cx, nx, t, m, 1'b0);
			p.ay = place(cy, ny, t, m, 1'b1);
			owed.push_back(p);
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_position(logic [7:0] ax, logic [7:0] ay);
			stick_pos_t p;
			if (owed.size() == 0) begin
				report($sformatf("unexpected position x=%0d y=%0d", ax, ay));
			end else begin
				p = owed.pop_front();
				if (ax !== p.ax) report($sformatf("axis_x %0d, wanted %0d", ax, p.ax));
				if (ay !== p.ay) report($sformatf("axis_y %0d, wanted %0d", ay, p.ay));
			end
		endtask
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [15:0] raw_x, raw_y;
	logic [7:0] axis_x, axis_y;

	position_board board;
	bit calm;         // no idling on either side
	int hold_off;     // cycles the receiver still refuses output transfers

	stick_radial_deadzone_scaler_core dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// runaway guard
	initial begin
		#3000000;
		$display("end of test: mismatches");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (hold_off > 0) hold_off <= hold_off - 1;
			out_ready <= (hold_off <= 1) && (calm || $urandom_range(99) >= 6);
		end
	end

	// output transfers checked at the edge where they happen
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_position(axis_x, axis_y);
	end

	task apb_write(srdz_pkg::reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 3'(idx) << 2; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == srdz_pkg::REG_DEADZONE) board.dz_q16 = val[15:0];
		else board.span = val[6:0];
	endtask

	// offers one pair and holds it until the transfer; valid drops only while idling
	task send_pair(logic signed [15:0] x, logic signed [15:0] y);
		if (!calm) begin
			while ($urandom_range(99) < 6) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1; raw_x <= x; raw_y <= y;
		do @(posedge clk); while (!in_ready);
		board.note_sample(x, y);
	endtask

	// lets every owed position arrive, then the pipe latency
	task drain();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (board.owed.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (40) @(posedge clk);
	endtask

	// mostly random values over the full range, with extremes and near-centre readings mixed in
	function automatic logic signed [15:0] pick_axis();
		case ($urandom_range(5))
			0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			1: return 16'($urandom_range(8)) - 16'sd4;
			default: return 16'($urandom);
		endcase
	endfunction

	task random_run(int count);
		repeat (count) send_pair(pick_axis(), pick_axis());
	endtask

	logic signed [15:0] edges[6] = '{16'sh8000, 16'sh7fff, 0, -1, 16'sd3277, -16'sd3277};

	initial begin
		board = new();
		calm = 0; hold_off = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; raw_x = 0; raw_y = 0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes and corners at the reset settings
		foreach (edges[i]) send_pair(edges[i], edges[(i + 1) % 6]);
		send_pair(16'sh7fff, 16'sh7fff);
		send_pair(16'sh8000, 16'sh8000);
		send_pair(16'sh8000, 16'sh7fff);
		send_pair(16'sh5555, 16'shaaaa);
		send_pair(16'shaaaa, 16'sh5555);
		send_pair(0, 16'sh7fff);
		random_run(150);
		drain();

		// full deadzone with full span
		apb_write(srdz_pkg::REG_DEADZONE, 32'hffff);
		apb_write(srdz_pkg::REG_SPAN, 32'd127);
		send_pair(16'sh7fff, 16'sh7fff);
		send_pair(16'sh7fff, 0);
		random_run(100);
		drain();

		// no deadzone, zero span: both axes at centre
		apb_write(srdz_pkg::REG_DEADZONE, 32'h0);
		apb_write(srdz_pkg::REG_SPAN, 32'd0);
		send_pair(16'sh8000, 16'sh7fff);
		random_run(80);
		drain();

		// no deadzone, full span; long receiver hold-off to fill the pipe
		apb_write(srdz_pkg::REG_SPAN, 32'd127);
		hold_off = 200;
		random_run(120);
		drain();

		// random settings, one stretch with no idling at all
		repeat (3) begin
			apb_write(srdz_pkg::REG_DEADZONE, $urandom_range(65535));
			apb_write(srdz_pkg::REG_SPAN, $urandom_range(127));
			random_run(70);
			drain();
		end
		calm = 1;
		random_run(100);
		calm = 0;
		drain();

		if (board.errors == 0 && board.owed.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

FILE: sim.f
rtl/core/srdz_pkg.sv
rtl/core/srdz_sqrt.sv
rtl/core/srdz_div.sv
rtl/core/stick_radial_deadzone_scaler_core.sv
test/stick_radial_deadzone_scaler_core_tb.sv
